// ----- rtl/hevl_pkg.sv -----
// Shared constants and types for the half-ellipsoid voxel labeler.
`default_nettype none
package hevl_pkg;

  localparam int DimXDef      = 64;
  localparam int DimYDef      = 64;
  localparam int DimZDef      = 64;
  localparam int MaxRadiusDef = 16;

  localparam int CfgW    = 7;
  localparam int CfgIdxW = 2;
  localparam int RadW    = 12;
  localparam int NrmW    = 16;
  localparam int PosW    = 6;
  localparam int LabW    = 8;
  localparam int CntW    = 16;
  localparam int RrW     = 2 * RadW;
  localparam int QW      = 33;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_STAMP = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  localparam logic [CfgIdxW-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SIZE_Z = 2'd2;

endpackage
`default_nettype wire

// ----- rtl/hevl_if.sv -----
// Input and result channel interfaces.
`default_nettype none
interface hevl_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [hevl_pkg::PosW-1:0]     pos_x;
  logic [hevl_pkg::PosW-1:0]     pos_y;
  logic [hevl_pkg::PosW-1:0]     pos_z;
  logic                          mask_bit;
  logic [hevl_pkg::RadW-1:0]     radius_x;
  logic [hevl_pkg::RadW-1:0]     radius_y;
  logic [hevl_pkg::RadW-1:0]     radius_z;
  logic signed [hevl_pkg::NrmW-1:0] normal_x;
  logic signed [hevl_pkg::NrmW-1:0] normal_y;
  logic signed [hevl_pkg::NrmW-1:0] normal_z;
  logic [hevl_pkg::LabW-1:0]     label;

  modport source (output valid, kind, pos_x, pos_y, pos_z, mask_bit, radius_x, radius_y,
                  radius_z, normal_x, normal_y, normal_z, label, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, pos_z, mask_bit, radius_x, radius_y,
                  radius_z, normal_x, normal_y, normal_z, label, output ready);
endinterface

interface hevl_out_if;
  logic                      valid;
  logic                      ready;
  logic [hevl_pkg::LabW-1:0] label_value;
  logic [hevl_pkg::CntW-1:0] voxels_written;

  modport source (output valid, label_value, voxels_written, input ready);
  modport sink   (input valid, label_value, voxels_written, output ready);
endinterface
`default_nettype wire

// ----- rtl/half_ellipsoid_voxel_labeler.sv -----
// Half-ellipsoid voxel labeler: mask and label volumes in RAM, stamp walker.
// An in-range load writes the mask bit, an in-range read returns the label from the registered
// RAM read, and a clear sweeps the label RAM. A stamp builds the per-axis term tables on the
// shared divider, then walks every voxel of the clipped box. One item in flight.
// After reset a sweep over every address clears both RAMs; no item is taken until it ends.
// Configuration resets to 64 on every axis.
`default_nettype none
module half_ellipsoid_voxel_labeler #(
  parameter int DIM_X      = hevl_pkg::DimXDef,
  parameter int DIM_Y      = hevl_pkg::DimYDef,
  parameter int DIM_Z      = hevl_pkg::DimZDef,
  parameter int MAX_RADIUS = hevl_pkg::MaxRadiusDef
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  hevl_in_if.sink                           in_ch,
  hevl_out_if.source                        out_ch,
  input  wire logic                         cfg_we,
  input  wire logic [hevl_pkg::CfgIdxW-1:0] cfg_idx,
  input  wire logic [hevl_pkg::CfgW-1:0]    cfg_data
);
  localparam int Depth = DIM_X * DIM_Y * DIM_Z;
  localparam int AW    = $clog2(Depth);
  localparam int TD    = MAX_RADIUS + 1;
  localparam int TIW   = (TD > 2) ? $clog2(TD) : 1;
  localparam int NW    = 2 * TIW + 16;
  localparam int DOTW  = 28;
  localparam int CW    = hevl_pkg::CfgW;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLR, S_BOX, S_TMUL, S_TSTART, S_TDIV, S_DOT,
    S_ADR1, S_ADR2, S_LOAD, S_RD, S_RDW, S_WALK, S_DRAIN, S_DONE
  } state_t;

  state_t state_r;

  logic [CW-1:0] size_r [3];
  logic [CW-1:0] lim [3];

  // item fields
  hevl_pkg::kind_t                   kind_r;
  logic [hevl_pkg::PosW-1:0]         pos_r [3];
  logic                              mbit_r;
  logic [hevl_pkg::RadW-1:0]         rad_r [3];
  logic signed [hevl_pkg::NrmW-1:0]  nrm_r [3];
  logic [hevl_pkg::LabW-1:0]         lab_r;

  // box
  logic [CW-1:0]  lo_r [3];
  logic [CW-1:0]  hi_r [3];
  logic [TIW-1:0] ext_r [3];
  logic [CW-1:0]  lo_c [3];
  logic [CW-1:0]  hi_c [3];
  logic [TIW-1:0] ext_c [3];
  logic           box_empty;

  // per-axis term tables
  logic [hevl_pkg::QW-1:0] q_tbl_r  [3][TD];
  logic                    ok_tbl_r [3][TD];
  logic [1:0]              tax_r;
  logic [TIW-1:0]          tad_r;
  logic [NW-1:0]           n_r;
  logic [hevl_pkg::RrW-1:0] rr_r;
  logic                    div_start;
  logic                    div_done;
  logic [hevl_pkg::QW-1:0] div_q;

  // dot product and walker
  logic [1:0]             dcnt_r;
  logic signed [DOTW-1:0] dot_r, row_dot_r, plane_dot_r;
  logic signed [8:0]      doff;
  logic signed [DOTW-1:0] dprod;
  logic [CW-1:0]          w_r [3];
  logic [AW-1:0]          addr_r, row_addr_r, plane_addr_r, t_r;
  logic [TIW-1:0]         ad [3];
  logic [hevl_pkg::QW+1:0] qsum;
  logic                   keep;

  logic                   s1_v_r, s1_keep_r;
  logic [AW-1:0]          s1_addr_r;

  logic [AW-1:0]          clr_addr_r;
  logic [hevl_pkg::LabW-1:0] res_lab_r;
  logic [hevl_pkg::CntW-1:0] count_r;
  logic                   out_valid_r;
  logic [hevl_pkg::LabW-1:0] out_lab_r;
  logic [hevl_pkg::CntW-1:0] out_cnt_r;

  // RAM ports
  logic                      lbl_we, msk_we;
  logic [AW-1:0]             lbl_waddr, msk_waddr;
  logic [hevl_pkg::LabW-1:0] lbl_wdata, lbl_q;
  logic                      msk_wdata, msk_q;
  logic                      lbl_hit;
  logic                      in_range;

  always_comb begin
    lim[0] = (int'(size_r[0]) > DIM_X) ? CW'(DIM_X) : size_r[0];
    lim[1] = (int'(size_r[1]) > DIM_Y) ? CW'(DIM_Y) : size_r[1];
    lim[2] = (int'(size_r[2]) > DIM_Z) ? CW'(DIM_Z) : size_r[2];
    in_range = (CW'(pos_r[0]) < lim[0]) && (CW'(pos_r[1]) < lim[1]) &&
               (CW'(pos_r[2]) < lim[2]);
  end

  // bounding box, clipped to the extents in use
  always_comb begin
    logic [12:0]       rsum;
    logic [4:0]        eraw;
    logic signed [9:0] los, his, limm1;
    box_empty = 1'b0;
    for (int a = 0; a < 3; a++) begin
      rsum     = 13'(rad_r[a]) + 13'd255;
      eraw     = rsum[12:8];
      ext_c[a] = (int'(eraw) > MAX_RADIUS) ? TIW'(MAX_RADIUS) : TIW'(eraw);
      los      = signed'(10'(pos_r[a])) - signed'(10'(ext_c[a]));
      his      = signed'(10'(pos_r[a])) + signed'(10'(ext_c[a]));
      limm1    = signed'(10'(lim[a])) - 10'sd1;
      if (los < 10'sd0) los = 10'sd0;
      if (his > limm1) his = limm1;
      if (his < los) box_empty = 1'b1;
      lo_c[a] = los[CW-1:0];
      hi_c[a] = his[CW-1:0];
    end
  end

  // voxel test from the tables and the running dot product
  always_comb begin
    logic signed [8:0] d;
    logic              okall;
    okall = 1'b1;
    qsum  = '0;
    for (int a = 0; a < 3; a++) begin
      d     = signed'(9'(w_r[a])) - signed'(9'(pos_r[a]));
      ad[a] = d[8] ? TIW'(-d) : TIW'(d);
      okall = okall & ok_tbl_r[a][ad[a]];
      qsum  = qsum + (hevl_pkg::QW+2)'(q_tbl_r[a][ad[a]]);
    end
    keep = okall && (qsum <= (hevl_pkg::QW+2)'(64'h1_0000_0000)) && dot_r[DOTW-1];
  end

  always_comb begin
    doff  = signed'(9'(lo_r[dcnt_r])) - signed'(9'(pos_r[dcnt_r]));
    dprod = DOTW'(doff * nrm_r[dcnt_r]);
  end

  assign div_start = (state_r == S_TSTART);
  assign lbl_hit   = s1_v_r && s1_keep_r && msk_q && (lbl_q == '0);

  always_comb begin
    lbl_we    = 1'b0;
    lbl_waddr = s1_addr_r;
    lbl_wdata = lab_r;
    msk_we    = 1'b0;
    msk_waddr = addr_r;
    msk_wdata = mbit_r;
    if (state_r == S_INIT || state_r == S_CLR) begin
      lbl_we    = 1'b1;
      lbl_waddr = clr_addr_r;
      lbl_wdata = '0;
    end else if (lbl_hit) begin
      lbl_we = 1'b1;
    end
    if (state_r == S_INIT) begin
      msk_we    = 1'b1;
      msk_waddr = clr_addr_r;
      msk_wdata = 1'b0;
    end else if (state_r == S_LOAD) begin
      msk_we = 1'b1;
    end
  end

  hevl_ram #(.W(hevl_pkg::LabW), .D(Depth)) u_lbl_ram (
    .clk, .we(lbl_we), .waddr(lbl_waddr), .wdata(lbl_wdata), .raddr(addr_r), .rdata(lbl_q)
  );

  hevl_ram #(.W(1), .D(Depth)) u_msk_ram (
    .clk, .we(msk_we), .waddr(msk_waddr), .wdata(msk_wdata), .raddr(addr_r), .rdata(msk_q)
  );

  hevl_div #(.NW(NW)) u_div (
    .clk, .rst_n, .start(div_start), .num(n_r), .den(rr_r), .done(div_done), .quot(div_q)
  );

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.label_value    = out_lab_r;
  assign out_ch.voxels_written = out_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      s1_v_r      <= 1'b0;
      size_r[0]   <= CW'(64);
      size_r[1]   <= CW'(64);
      size_r[2]   <= CW'(64);
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          hevl_pkg::REG_SIZE_X: size_r[0] <= cfg_data;
          hevl_pkg::REG_SIZE_Y: size_r[1] <= cfg_data;
          hevl_pkg::REG_SIZE_Z: size_r[2] <= cfg_data;
          default: ;
        endcase
      end
      // in S_DONE the result register is reloaded below
      if (out_valid_r && out_ch.ready && state_r != S_DONE) out_valid_r <= 1'b0;

      // label write-back stage
      s1_v_r    <= (state_r == S_WALK);
      s1_keep_r <= keep;
      s1_addr_r <= addr_r;
      if (lbl_hit && count_r != '1) count_r <= count_r + 1'b1;

      unique case (state_r)
        S_INIT, S_CLR: begin
          if (clr_addr_r == AW'(Depth - 1)) begin
            clr_addr_r <= '0;
            state_r    <= (state_r == S_INIT) ? S_IDLE : S_DONE;
          end else begin
            clr_addr_r <= clr_addr_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            kind_r    <= hevl_pkg::kind_t'(in_ch.kind);
            pos_r[0]  <= in_ch.pos_x;
            pos_r[1]  <= in_ch.pos_y;
            pos_r[2]  <= in_ch.pos_z;
            mbit_r    <= in_ch.mask_bit;
            rad_r[0]  <= in_ch.radius_x;
            rad_r[1]  <= in_ch.radius_y;
            rad_r[2]  <= in_ch.radius_z;
            nrm_r[0]  <= in_ch.normal_x;
            nrm_r[1]  <= in_ch.normal_y;
            nrm_r[2]  <= in_ch.normal_z;
            lab_r     <= in_ch.label;
            res_lab_r <= '0;
            count_r   <= '0;
            unique case (hevl_pkg::kind_t'(in_ch.kind))
              hevl_pkg::KIND_CLEAR: state_r <= S_CLR;
              hevl_pkg::KIND_STAMP: state_r <= (in_ch.label == '0) ? S_DONE : S_BOX;
              default:              state_r <= S_ADR1;
            endcase
          end
        end
        S_BOX: begin
          for (int a = 0; a < 3; a++) begin
            lo_r[a]  <= lo_c[a];
            hi_r[a]  <= hi_c[a];
            ext_r[a] <= ext_c[a];
          end
          tax_r   <= '0;
          tad_r   <= '0;
          state_r <= box_empty ? S_DONE : S_TMUL;
        end
        S_TMUL: begin
          n_r     <= NW'({(2*TIW)'(tad_r * tad_r), 16'h0000});
          rr_r    <= rad_r[tax_r] * rad_r[tax_r];
          state_r <= S_TSTART;
        end
        S_TSTART: state_r <= S_TDIV;
        S_TDIV: begin
          if (div_done) begin
            // zero offset always contributes nothing; a term above one rejects
            q_tbl_r[tax_r][tad_r]  <= (tad_r == '0) ? '0 : div_q;
            ok_tbl_r[tax_r][tad_r] <= (tad_r == '0) || (NW'(rr_r) >= n_r);
            if (tad_r == ext_r[tax_r]) begin
              tad_r <= '0;
              if (tax_r == 2'd2) begin
                dcnt_r  <= '0;
                dot_r   <= '0;
                state_r <= S_DOT;
              end else begin
                tax_r   <= tax_r + 1'b1;
                state_r <= S_TMUL;
              end
            end else begin
              tad_r   <= tad_r + 1'b1;
              state_r <= S_TMUL;
            end
          end
        end
        S_DOT: begin
          dot_r  <= dot_r + dprod;
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == 2'd2) begin
            for (int a = 0; a < 3; a++) w_r[a] <= lo_r[a];
            state_r <= S_ADR1;
          end
        end
        S_ADR1: begin
          if (kind_r == hevl_pkg::KIND_STAMP) begin
            t_r         <= AW'(AW'(lo_r[2]) * AW'(DIM_Y) + AW'(lo_r[1]));
            row_dot_r   <= dot_r;
            plane_dot_r <= dot_r;
            state_r     <= S_ADR2;
          end else begin
            t_r     <= AW'(AW'(pos_r[2]) * AW'(DIM_Y) + AW'(pos_r[1]));
            state_r <= in_range ? S_ADR2 : S_DONE;
          end
        end
        S_ADR2: begin
          if (kind_r == hevl_pkg::KIND_STAMP) begin
            addr_r       <= AW'(t_r * AW'(DIM_X) + AW'(lo_r[0]));
            row_addr_r   <= AW'(t_r * AW'(DIM_X) + AW'(lo_r[0]));
            plane_addr_r <= AW'(t_r * AW'(DIM_X) + AW'(lo_r[0]));
            state_r      <= S_WALK;
          end else begin
            addr_r  <= AW'(t_r * AW'(DIM_X) + AW'(pos_r[0]));
            state_r <= (kind_r == hevl_pkg::KIND_LOAD) ? S_LOAD : S_RD;
          end
        end
        S_LOAD: state_r <= S_DONE;
        S_RD:   state_r <= S_RDW;
        S_RDW: begin
          res_lab_r <= lbl_q;
          state_r   <= S_DONE;
        end
        S_WALK: begin
          priority if (w_r[0] != hi_r[0]) begin
            w_r[0] <= w_r[0] + 1'b1;
            addr_r <= addr_r + 1'b1;
            dot_r  <= dot_r + DOTW'(nrm_r[0]);
          end else if (w_r[1] != hi_r[1]) begin
            w_r[0]     <= lo_r[0];
            w_r[1]     <= w_r[1] + 1'b1;
            row_addr_r <= row_addr_r + AW'(DIM_X);
            addr_r     <= row_addr_r + AW'(DIM_X);
            row_dot_r  <= row_dot_r + DOTW'(nrm_r[1]);
            dot_r      <= row_dot_r + DOTW'(nrm_r[1]);
          end else if (w_r[2] != hi_r[2]) begin
            w_r[0]       <= lo_r[0];
            w_r[1]       <= lo_r[1];
            w_r[2]       <= w_r[2] + 1'b1;
            plane_addr_r <= plane_addr_r + AW'(DIM_X * DIM_Y);
            row_addr_r   <= plane_addr_r + AW'(DIM_X * DIM_Y);
            addr_r       <= plane_addr_r + AW'(DIM_X * DIM_Y);
            plane_dot_r  <= plane_dot_r + DOTW'(nrm_r[2]);
            row_dot_r    <= plane_dot_r + DOTW'(nrm_r[2]);
            dot_r        <= plane_dot_r + DOTW'(nrm_r[2]);
          end else begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: state_r <= S_DONE;
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_lab_r   <= res_lab_r;
            out_cnt_r   <= count_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/hevl_ram.sv -----
// Generic single-clock RAM, one write port, one registered read port.
`default_nettype none
module hevl_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/hevl_div.sv -----
// Restoring divider: q = floor(n * 2^32 / d) for n < 2*d, one quotient bit a cycle.
`default_nettype none
module hevl_div #(
  parameter int NW = 30
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [NW-1:0]             num,
  input  wire logic [hevl_pkg::RrW-1:0]  den,
  output logic                           done,
  output logic      [hevl_pkg::QW-1:0]   quot
);
  localparam int RW = ((NW > hevl_pkg::RrW) ? NW : hevl_pkg::RrW) + 1;
  localparam int CW = $clog2(hevl_pkg::QW + 1);

  logic [RW-1:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          first_r;
  logic [RW:0]   trial;
  logic          ge;

  always_comb begin
    trial = first_r ? {1'b0, rem_r} : {rem_r, 1'b0};
    ge    = trial >= (RW+1)'(den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        first_r <= 1'b1;
        rem_r   <= RW'(num);
        cnt_r   <= CW'(hevl_pkg::QW);
      end else if (busy_r) begin
        first_r <= 1'b0;
        rem_r   <= ge ? RW'(trial - (RW+1)'(den)) : RW'(trial);
        quot    <= {quot[hevl_pkg::QW-2:0], ge};
        cnt_r   <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- tb/hevl_tb_pkg.sv -----
// Item and result types used by the labeler testbench.
package hevl_tb_pkg;
  import hevl_pkg::*;

  typedef struct {
    kind_t                  kind;
    logic [PosW-1:0]        px, py, pz;
    logic                   mb;
    logic [RadW-1:0]        rx, ry, rz;
    logic signed [NrmW-1:0] nx, ny, nz;
    logic [LabW-1:0]        lab;
  } vox_cmd_t;

  typedef struct {
    logic [LabW-1:0] label_value;
    logic [CntW-1:0] voxels_written;
  } vox_res_t;
endpackage

// ----- tb/half_ellipsoid_voxel_labeler_tb.sv -----
// Self-checking testbench for the half-ellipsoid voxel labeler.
module half_ellipsoid_voxel_labeler_tb;
  import hevl_pkg::*;
  import hevl_tb_pkg::*;

  localparam int Dim      = 64;
  localparam int VolDepth = Dim * Dim * Dim;
  localparam int MaxRad   = 16;
  localparam int IdleLimit = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgW-1:0] cfg_data = '0;

  hevl_in_if  in_ch();
  hevl_out_if out_ch();

  half_ellipsoid_voxel_labeler u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [LabW-1:0] label_mem [VolDepth];
  bit              mask_mem  [VolDepth];
  int              ext_reg   [3];
  vox_res_t        pending_q [$];
  int              errors = 0;
  bit              hold_out = 1'b0;
  int              idle_cycles = 0;

  function automatic int ext_used(int a);
    return (ext_reg[a] > Dim) ? Dim : ext_reg[a];
  endfunction

  function automatic bit axis_term(int d, logic [RadW-1:0] r, output longint unsigned q);
    longint unsigned ad, n, rr;
    q = 0;
    if (d == 0) return 1'b1;
    if (r == 0) return 1'b0;
    ad = (d < 0) ? -d : d;
    n  = ad * ad * 65536;
    rr = longint'(r) * longint'(r);
    if (n > rr) return 1'b0;
    q = (n << 32) / rr;
    return 1'b1;
  endfunction

  function automatic void box_bounds(int cen, logic [RadW-1:0] r, int lim,
                                     output int lo, output int hi);
    int e;
    e = (int'(r) + 255) >> 8;
    if (e > MaxRad) e = MaxRad;
    lo = (cen - e < 0) ? 0 : cen - e;
    hi = (cen + e > lim - 1) ? lim - 1 : cen + e;
  endfunction

  function automatic logic [CntW-1:0] stamp_voxels(vox_cmd_t c);
    int x0, x1, y0, y1, z0, z1, dx, dy, dz, a, cnt;
    longint unsigned qx, qy, qz;
    longint dot;
    cnt = 0;
    if (c.lab == 0) return '0;
    box_bounds(c.px, c.rx, ext_used(0), x0, x1);
    box_bounds(c.py, c.ry, ext_used(1), y0, y1);
    box_bounds(c.pz, c.rz, ext_used(2), z0, z1);
    for (int z = z0; z <= z1; z++)
      for (int y = y0; y <= y1; y++)
        for (int x = x0; x <= x1; x++) begin
          dx = x - c.px; dy = y - c.py; dz = z - c.pz;
          if (!axis_term(dx, c.rx, qx) || !axis_term(dy, c.ry, qy) ||
              !axis_term(dz, c.rz, qz)) continue;
          if (qx + qy + qz > 64'h1_0000_0000) continue;
          dot = longint'(dx) * c.nx + longint'(dy) * c.ny + longint'(dz) * c.nz;
          if (dot >= 0) continue;
          a = (z * Dim + y) * Dim + x;
          if (!mask_mem[a] || label_mem[a] != 0) continue;
          label_mem[a] = c.lab;
          if (cnt < 65535) cnt++;
        end
    return cnt[CntW-1:0];
  endfunction

  function automatic vox_res_t predict_result(vox_cmd_t c);
    vox_res_t r;
    bit ok;
    int a;
    r = '{label_value: '0, voxels_written: '0};
    ok = c.px < ext_used(0) && c.py < ext_used(1) && c.pz < ext_used(2);
    a = (int'(c.pz) * Dim + c.py) * Dim + c.px;
    case (c.kind)
      KIND_LOAD:  if (ok) mask_mem[a] = c.mb;
      KIND_STAMP: r.voxels_written = stamp_voxels(c);
      KIND_READ:  if (ok) r.label_value = label_mem[a];
      default:    foreach (label_mem[i]) label_mem[i] = '0;
    endcase
    return r;
  endfunction

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  task automatic send_item(vox_cmd_t c);
    vox_res_t exp_res;
    in_ch.valid <= 1'b1;
    in_ch.kind <= c.kind;
    in_ch.pos_x <= c.px; in_ch.pos_y <= c.py; in_ch.pos_z <= c.pz;
    in_ch.mask_bit <= c.mb;
    in_ch.radius_x <= c.rx; in_ch.radius_y <= c.ry; in_ch.radius_z <= c.rz;
    in_ch.normal_x <= c.nx; in_ch.normal_y <= c.ny; in_ch.normal_z <= c.nz;
    in_ch.label <= c.lab;
    do @(posedge clk); while (!in_ch.ready);
    exp_res = predict_result(c);
    pending_q = {pending_q, exp_res};
    if ($urandom_range(0, 3) != 0) begin
      int g;
      g = short_gap();
      if (g > 0) begin
        in_ch.valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int val);
    in_ch.valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val[CfgW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    ext_reg[idx] = val & 8'h7f;
  endtask

  task automatic set_extents(int sx, int sy, int sz);
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
  endtask

  function automatic vox_cmd_t make_cmd(kind_t k, int x, int y, int z);
    vox_cmd_t c;
    c.kind = k; c.px = PosW'(x); c.py = PosW'(y); c.pz = PosW'(z); c.mb = 1'b1;
    c.rx = 12'h200; c.ry = 12'h200; c.rz = 12'h200;
    c.nx = 16'sh0100; c.ny = 16'sh0100; c.nz = -16'sh0100;
    c.lab = 8'h5a;
    return c;
  endfunction

  function automatic vox_cmd_t noise_cmd();
    vox_cmd_t c;
    c.kind = kind_t'($urandom_range(0, 2));
    c.px = PosW'($urandom); c.py = PosW'($urandom); c.pz = PosW'($urandom);
    c.mb = 1'($urandom);
    // large radii only now and then; the box volume sets the stamp time
    c.rx = RadW'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 800));
    c.ry = RadW'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 800));
    c.rz = RadW'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 800));
    c.nx = NrmW'($urandom); c.ny = NrmW'($urandom); c.nz = NrmW'($urandom);
    c.lab = LabW'($urandom);
    return c;
  endfunction

  // Mask a few voxels around a centre, stamp it, read back nearby labels.
  task automatic run_scene();
    vox_cmd_t c;
    int cx, cy, cz;
    cx = $urandom_range(0, 63); cy = $urandom_range(0, 63); cz = $urandom_range(0, 63);
    repeat ($urandom_range(3, 7)) begin
      c = noise_cmd();
      c.kind = KIND_LOAD;
      c.px = PosW'((cx + $urandom_range(0, 4) + 62) % 64);
      c.py = PosW'((cy + $urandom_range(0, 4) + 62) % 64);
      c.pz = PosW'((cz + $urandom_range(0, 4) + 62) % 64);
      c.mb = ($urandom_range(0, 4) != 0);
      send_item(c);
    end
    c = noise_cmd();
    c.kind = KIND_STAMP; c.px = PosW'(cx); c.py = PosW'(cy); c.pz = PosW'(cz);
    c.rx = RadW'($urandom_range(200, 800)); c.ry = RadW'($urandom_range(200, 800));
    c.rz = RadW'($urandom_range(200, 800));
    if ($urandom_range(0, 9) == 0) c.lab = '0;
    send_item(c);
    repeat ($urandom_range(2, 4)) begin
      c = noise_cmd();
      c.kind = KIND_READ;
      c.px = PosW'((cx + $urandom_range(0, 4) + 62) % 64);
      c.py = PosW'((cy + $urandom_range(0, 4) + 62) % 64);
      c.pz = PosW'((cz + $urandom_range(0, 4) + 62) % 64);
      send_item(c);
    end
  endtask

  task automatic test_directed_ops();
    vox_cmd_t c;
    send_item(make_cmd(KIND_LOAD, 0, 0, 0));
    send_item(make_cmd(KIND_LOAD, 63, 63, 63));
    send_item(make_cmd(KIND_LOAD, 1, 0, 0));
    send_item(make_cmd(KIND_LOAD, 62, 63, 63));
    // biggest radius at the corners, clipped box
    c = make_cmd(KIND_STAMP, 0, 0, 0);
    c.rx = 12'hfff; c.ry = 12'hfff; c.rz = 12'hfff; c.nx = -16'sh8000; c.nz = 16'sh7fff;
    send_item(c);
    c = make_cmd(KIND_STAMP, 63, 63, 63);
    c.rx = 12'hfff; c.ry = 12'h001; c.rz = 12'h001; c.nx = 16'sh7fff; c.lab = 8'hff;
    send_item(c);
    c = make_cmd(KIND_STAMP, 1, 0, 0);
    c.lab = 8'h00;
    send_item(c);
    c = make_cmd(KIND_STAMP, 1, 0, 0);
    c.nx = '0; c.ny = '0; c.nz = '0;
    send_item(c);
    c = make_cmd(KIND_STAMP, 2, 0, 0);
    c.rx = 12'h000; c.ry = 12'h000; c.rz = 12'h300; c.nx = 16'sh0100;
    send_item(c);
    send_item(make_cmd(KIND_READ, 0, 0, 0));
    send_item(make_cmd(KIND_READ, 1, 0, 0));
    send_item(make_cmd(KIND_READ, 62, 63, 63));
    send_item(make_cmd(KIND_CLEAR, 63, 63, 63));
    send_item(make_cmd(KIND_READ, 1, 0, 0));
    c = make_cmd(KIND_LOAD, 0, 0, 0);
    c.mb = 1'b0;
    send_item(c);
  endtask

  task automatic test_extents();
    vox_cmd_t c;
    set_extents(0, 64, 64);
    send_item(make_cmd(KIND_LOAD, 0, 5, 5));
    send_item(make_cmd(KIND_STAMP, 0, 5, 5));
    send_item(make_cmd(KIND_READ, 62, 63, 63));
    set_extents(1, 127, 1);
    send_item(make_cmd(KIND_LOAD, 0, 63, 0));
    send_item(make_cmd(KIND_LOAD, 1, 3, 0));
    c = make_cmd(KIND_STAMP, 0, 62, 0);
    c.ny = -16'sh0100; c.nz = '0; c.ry = 12'h400;
    send_item(c);
    send_item(make_cmd(KIND_READ, 0, 63, 0));
    send_item(make_cmd(KIND_READ, 62, 63, 63));
    set_extents(64, 64, 64);
  endtask

  task automatic test_random_scenes(int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 3) != 0) begin
        run_scene();
        sent += 10;
      end else begin
        send_item(noise_cmd());
        sent++;
      end
    end
  endtask

  // long enough for two of the slowest stamps to finish, so the block fills up
  task automatic test_backpressure();
    fork
      begin
        hold_out = 1'b1;
        repeat (100000) @(posedge clk);
        hold_out = 1'b0;
      end
    join_none
    repeat (12) send_item(noise_cmd());
  endtask

  // result ready with random gaps
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_ch.ready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) gap = short_gap();
      end
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    vox_res_t e;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("half_ellipsoid_voxel_labeler verification failed");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected transfer label %0d written %0d", $time,
                 out_ch.label_value, out_ch.voxels_written);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_ch.label_value !== e.label_value) begin
          $display("%0t: label_value expected %0d actual %0d", $time,
                   e.label_value, out_ch.label_value);
          errors++;
        end
        if (out_ch.voxels_written !== e.voxels_written) begin
          $display("%0t: voxels_written expected %0d actual %0d", $time,
                   e.voxels_written, out_ch.voxels_written);
          errors++;
        end
      end
    end
  end

  initial begin
    foreach (label_mem[i]) begin
      label_mem[i] = '0;
      mask_mem[i] = 1'b0;
    end
    ext_reg = '{64, 64, 64};
    in_ch.valid = 1'b0; in_ch.kind = KIND_LOAD;
    in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0; in_ch.mask_bit = 1'b0;
    in_ch.radius_x = '0; in_ch.radius_y = '0; in_ch.radius_z = '0;
    in_ch.normal_x = '0; in_ch.normal_y = '0; in_ch.normal_z = '0; in_ch.label = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_ops();
    test_extents();
    test_random_scenes(45);
    set_extents($urandom_range(1, 127), $urandom_range(1, 127), $urandom_range(1, 127));
    test_random_scenes(20);
    set_extents(127, 127, 127);
    test_backpressure();
    test_random_scenes(25);
    in_ch.valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("half_ellipsoid_voxel_labeler verification clean");
    end else begin
      $display("half_ellipsoid_voxel_labeler verification failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/hevl_pkg.sv
rtl/hevl_if.sv
rtl/hevl_ram.sv
rtl/hevl_div.sv
rtl/half_ellipsoid_voxel_labeler.sv
tb/hevl_tb_pkg.sv
tb/half_ellipsoid_voxel_labeler_tb.sv
